[sv/aes128_counter_word_generator_macros.svh]
`ifndef AES128_COUNTER_WORD_GENERATOR_MACROS_SVH
`define AES128_COUNTER_WORD_GENERATOR_MACROS_SVH
// implication checked every edge outside reset
`define ACWG_ASSERT_IMP(label, rst, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define ACWG_ASSERT_NXT(label, rst, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

[sv/acwg_pkg.sv]
package acwg_pkg;
   localparam int unsigned BlockBytes = 16;
   localparam int unsigned Rounds = 10;
   localparam int unsigned QueueDepth = 2;
   localparam logic [1:0] CSR_KEY_LOW = 2'd0;
   localparam logic [1:0] CSR_KEY_HIGH = 2'd1;
   localparam logic [1:0] CSR_COUNTER_START = 2'd2;

   typedef logic [8*BlockBytes-1:0] block_type;

   // front -> back job: counter for a new block, or a word from the current one
   typedef struct packed {
      logic        new_block;
      logic [63:0] counter;
      logic [1:0]  word_index;
   } job_type;

   function automatic logic [7:0] sbox(input logic [7:0] x);
      logic [7:0] t [256];
      t = '{
 8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
 8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
 8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
 8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
 8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
 8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
 8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
 8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
 8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
 8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
 8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
 8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
 8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
 8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
 8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
 8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
      return t[x];
   endfunction

   function automatic logic [7:0] xtime(input logic [7:0] x);
      return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
   endfunction

   // byte i of a block sits at bits [8i+7:8i]
   function automatic block_type aes_round(input block_type s, input block_type rk,
                                           input logic last);
      block_type sb, sr, mc;
      logic [7:0] a0, a1, a2, a3, al;
      for (int i = 0; i < 16; i++) sb[8*i +: 8] = sbox(s[8*i +: 8]);
      for (int c = 0; c < 4; c++)
         for (int r = 0; r < 4; r++)
            sr[8*(4*c+r) +: 8] = sb[8*(4*((c+r)%4)+r) +: 8];
      for (int c = 0; c < 4; c++) begin
         a0 = sr[8*(4*c) +: 8];
         a1 = sr[8*(4*c+1) +: 8];
         a2 = sr[8*(4*c+2) +: 8];
         a3 = sr[8*(4*c+3) +: 8];
         al = a0 ^ a1 ^ a2 ^ a3;
         mc[8*(4*c) +: 8] = a0 ^ al ^ xtime(a0 ^ a1);
         mc[8*(4*c+1) +: 8] = a1 ^ al ^ xtime(a1 ^ a2);
         mc[8*(4*c+2) +: 8] = a2 ^ al ^ xtime(a2 ^ a3);
         mc[8*(4*c+3) +: 8] = a3 ^ al ^ xtime(a3 ^ a0);
      end
      return (last ? sr : mc) ^ rk;
   endfunction

   // next round key from previous one; rk holds bytes in block order
   function automatic block_type next_round_key(input block_type rk, input logic [7:0] rc);
      block_type n;
      logic [31:0] t;
      t = {sbox(rk[103:96]), sbox(rk[127:120]), sbox(rk[119:112]),
           sbox(rk[111:104]) ^ rc};
      n[31:0] = rk[31:0] ^ t;
      n[63:32] = rk[63:32] ^ n[31:0];
      n[95:64] = rk[95:64] ^ n[63:32];
      n[127:96] = rk[127:96] ^ n[95:64];
      return n;
   endfunction

   function automatic logic [7:0] rcon(input logic [3:0] r);
      logic [7:0] v;
      case (r)
         4'd1: v = 8'h01;
         4'd2: v = 8'h02;
         4'd3: v = 8'h04;
         4'd4: v = 8'h08;
         4'd5: v = 8'h10;
         4'd6: v = 8'h20;
         4'd7: v = 8'h40;
         4'd8: v = 8'h80;
         4'd9: v = 8'h1b;
         4'd10: v = 8'h36;
         default: v = 8'h00;
      endcase
      return v;
   endfunction
endpackage

[sv/aes128_counter_word_generator.sv]
// Channel  Signals                               Direction
// req      req_valid req_stall req_request       in
// rsp      rsp_valid rsp_stall rsp_random_word   out
// csr      csr_valid csr_ready csr_index csr_data in
// One word per cycle in steady flow while rsp_stall is low; a request passes through the queue,
// the ten-stage round pipeline (round keys ride along) and the output register.
// A request with request low is taken and gives nothing.
// Reset is synchronous; afterwards key and counter are zero.
// rsp_stall with a word held in the output register freezes the round pipeline; the queue then backs up into req_stall.
module aes128_counter_word_generator #(
   parameter int unsigned QueueDepth = acwg_pkg::QueueDepth
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_request,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_random_word,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_data
);
   logic [63:0] key_low_ff, key_high_ff;
   logic        csr_take, q_push, q_nfull, q_nempty, q_pop;
   acwg_pkg::job_type q_in, q_out;

   assign csr_ready = 1'b1;
   assign csr_take = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_low_ff <= '0;
         key_high_ff <= '0;
      end else if (csr_take) begin
         case (csr_index)
            acwg_pkg::CSR_KEY_LOW: key_low_ff <= csr_data;
            acwg_pkg::CSR_KEY_HIGH: key_high_ff <= csr_data;
            default: ;
         endcase
      end
   end

   acwg_front u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_request(req_request),
      .load_counter(csr_take && csr_index == acwg_pkg::CSR_COUNTER_START),
      .load_value(csr_data),
      .job_valid(q_push), .job_ready(q_nfull), .job(q_in)
   );

   acwg_queue #(.Depth(QueueDepth)) u_queue (
      .clock(clock), .reset(reset),
      .push(q_push), .push_data(q_in), .not_full(q_nfull),
      .not_empty(q_nempty), .pop(q_pop), .pop_data(q_out)
   );

   acwg_back u_back (
      .clock(clock), .reset(reset),
      .key({key_high_ff, key_low_ff}),
      .job_valid(q_nempty), .job_pop(q_pop), .job(q_out),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_random_word(rsp_random_word)
   );
endmodule

[sv/acwg_front.sv]
module acwg_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_request,
   input  logic                load_counter,
   input  logic [63:0]         load_value,
   output logic                job_valid,
   input  logic                job_ready,
   output acwg_pkg::job_type   job
);
   logic [63:0] counter_ff, counter_in;
   logic [1:0]  index_ff, index_in;
   logic        take;

   assign req_stall = !job_ready;
   assign take = req_valid && !req_stall && req_request;
   assign job_valid = req_valid && req_request;
   assign job.new_block = (index_ff == 2'd0);
   assign job.counter = counter_ff + 64'd1;
   assign job.word_index = index_ff;

   always_comb begin
      counter_in = counter_ff;
      index_in = index_ff;
      if (load_counter) begin
         counter_in = load_value;
         index_in = 2'd0;
      end else if (take) begin
         index_in = index_ff + 2'd1;
         if (index_ff == 2'd0) counter_in = counter_ff + 64'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         counter_ff <= '0;
         index_ff <= '0;
      end else begin
         counter_ff <= counter_in;
         index_ff <= index_in;
      end
   end
endmodule

[sv/acwg_queue.sv]
module acwg_queue #(
   parameter int unsigned Depth = acwg_pkg::QueueDepth
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  acwg_pkg::job_type push_data,
   output logic              not_full,
   output logic              not_empty,
   input  logic              pop,
   output acwg_pkg::job_type pop_data
);
   `include "aes128_counter_word_generator_macros.svh"
   localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
   acwg_pkg::job_type mem_ff [Depth];
   logic [AW-1:0] wr_ff, rd_ff;
   logic [AW:0]   count_ff;

   function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
      return (p == AW'(Depth - 1)) ? '0 : p + AW'(1);
   endfunction

   assign not_full = (count_ff != (AW+1)'(Depth));
   assign not_empty = (count_ff != '0);
   assign pop_data = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push && not_full) mem_ff[wr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         count_ff <= '0;
      end else begin
         if (push && not_full) wr_ff <= bump(wr_ff);
         if (pop && not_empty) rd_ff <= bump(rd_ff);
         count_ff <= count_ff + (AW+1)'(push && not_full) - (AW+1)'(pop && not_empty);
      end
   end

   `ACWG_ASSERT_IMP(a_q_bound, reset, 1'b1, count_ff <= (AW+1)'(Depth), "queue overfilled")
   `ACWG_ASSERT_NXT(a_q_push_empty, reset, push && !not_empty && !pop, not_empty,
                    "pushed entry lost")
   `ACWG_ASSERT_NXT(a_q_hold, reset, not_empty && !pop && !push, $stable(count_ff),
                    "count moved while idle")
endmodule

[sv/acwg_back.sv]
module acwg_back (
   input  logic                 clock,
   input  logic                 reset,
   input  acwg_pkg::block_type  key,
   input  logic                 job_valid,
   output logic                 job_pop,
   input  acwg_pkg::job_type    job,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [31:0]          rsp_random_word
);
   `include "aes128_counter_word_generator_macros.svh"
   localparam int unsigned Stages = acwg_pkg::Rounds;
   // pipeline: stage k holds state after round k, round key k, word index
   acwg_pkg::block_type st_ff [Stages+1];
   acwg_pkg::block_type rk_ff [Stages+1];
   logic [1:0]          wi_ff [Stages+1];
   logic                nb_ff [Stages+1];
   logic [Stages:0]     v_ff;
   acwg_pkg::block_type blk_ff;
   logic                out_v_ff;
   logic [31:0]         out_w_ff;
   logic                adv, in_take, tail_take;
   acwg_pkg::block_type cur_blk;

   // whole pipe advances together when output can take the tail
   assign adv = !(out_v_ff && rsp_stall);
   assign in_take = adv && job_valid;
   assign job_pop = in_take;
   assign tail_take = adv && v_ff[Stages];
   assign cur_blk = nb_ff[Stages] ? st_ff[Stages] : blk_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         st_ff[0] <= {job.counter, 64'd0} ^ key;
         rk_ff[0] <= key;
         wi_ff[0] <= job.word_index;
         nb_ff[0] <= job.new_block;
         for (int k = 1; k <= Stages; k++) begin
            rk_ff[k] <= acwg_pkg::next_round_key(rk_ff[k-1], acwg_pkg::rcon(4'(k)));
            st_ff[k] <= acwg_pkg::aes_round(st_ff[k-1],
               acwg_pkg::next_round_key(rk_ff[k-1], acwg_pkg::rcon(4'(k))), k == Stages);
            wi_ff[k] <= wi_ff[k-1];
            nb_ff[k] <= nb_ff[k-1];
         end
      end
      if (tail_take) begin
         if (nb_ff[Stages]) blk_ff <= st_ff[Stages];
         out_w_ff <= cur_blk[32*wi_ff[Stages] +: 32];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
         out_v_ff <= 1'b0;
      end else begin
         if (adv) v_ff <= {v_ff[Stages-1:0], job_valid};
         if (adv) out_v_ff <= v_ff[Stages];
      end
   end

   assign rsp_valid = out_v_ff;
   assign rsp_random_word = out_w_ff;

   `ACWG_ASSERT_NXT(a_b_stall_hold, reset, out_v_ff && rsp_stall,
                    out_v_ff && $stable(out_w_ff), "stalled result changed")
   `ACWG_ASSERT_NXT(a_b_deliver, reset, tail_take, out_v_ff, "finished word dropped")
   `ACWG_ASSERT_IMP(a_b_pop, reset, job_pop, job_valid, "pop without job")
endmodule
